[hw/rtl/wws_pkg.sv]
`default_nettype none

package wws_pkg;

    localparam int DEF_MAX_SAMPLES = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int WIN_W      = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END   = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RST_SAMPLE_COUNT = 11'd1024;
    localparam logic [WIN_W-1:0]      RST_WINDOW_START = 10'd0;
    localparam logic [WIN_W-1:0]      RST_WINDOW_END   = 10'd1023;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_GSTART,
        ST_GRUN,
        ST_RSTART,
        ST_RRUN,
        ST_LOAD
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic acc_en;      // sample beat accepted
        logic div_start;   // launch divider
        logic div_region;  // 0: waveform sum, 1: region sum
        logic save_gmean;  // capture waveform mean
        logic load_out;    // fill output register, restart accumulators
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;        // current sample ends the waveform
        logic div_done;    // divider result ready
    } sts_t;

endpackage

`default_nettype wire

[hw/rtl/waveform_window_statistics.sv]
// Waveform statistics over a full waveform and over an analysis region.
// Input: s_sample beats (valid/ready), one digitized sample per beat; the
// sample index is counted inside, the waveform ends after sample_count beats.
// Output: one result beat (valid/ready) per waveform with global min, max,
// mean and region min, max, spread, abs peak, mean and two flags.
// Config: cfg_index/cfg_data beats; cfg_ready is always high. Write only
// while no waveform result is pending.
// Throughput: one sample per cycle inside a waveform. After the last sample
// the input stalls while one shared radix-2 divider forms the two means,
// waveform mean first, then region mean, and until the result is handed
// to the output register.
// The output register decouples the two sides: while a result waits for
// m_ready, the next waveform streams in; only its final result hand-off
// waits until the previous result beat is taken.
// Reset (aresetn low, synchronous): registers return to sample_count 1024,
// window 0..1023, all accumulators cleared, no result pending.
`default_nettype none

module waveform_window_statistics #(
    parameter int MAX_SAMPLES = wws_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = wws_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [wws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wws_pkg::CFG_DATA_W-1:0] cfg_data,
    // sample channel
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]  s_sample,
    // result channel
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [SAMPLE_BITS-1:0]       m_global_min,
    output logic signed [SAMPLE_BITS-1:0]       m_global_max,
    output logic signed [SAMPLE_BITS-1:0]       m_global_mean,
    output logic signed [SAMPLE_BITS-1:0]       m_region_min,
    output logic signed [SAMPLE_BITS-1:0]       m_region_max,
    output logic [SAMPLE_BITS-1:0]              m_region_spread,
    output logic signed [SAMPLE_BITS-1:0]       m_region_abs_peak,
    output logic signed [SAMPLE_BITS-1:0]       m_region_mean,
    output logic                                m_region_valid,
    output logic                                m_mean_valid
);

    import wws_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // registers accept any beat; the user must write only with the block idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    // sequencing: accumulate, two divides, then hand off to output register
    wws_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // accumulators, config registers, divider and result register
    wws_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_sample          (s_sample),
        .cmd               (cmd),
        .sts               (sts),
        .m_global_min      (m_global_min),
        .m_global_max      (m_global_max),
        .m_global_mean     (m_global_mean),
        .m_region_min      (m_region_min),
        .m_region_max      (m_region_max),
        .m_region_spread   (m_region_spread),
        .m_region_abs_peak (m_region_abs_peak),
        .m_region_mean     (m_region_mean),
        .m_region_valid    (m_region_valid),
        .m_mean_valid      (m_mean_valid)
    );

endmodule

`default_nettype wire

[hw/rtl/wws_div.sv]
`default_nettype none

module wws_div #(
    parameter int DVD_W = 26,
    parameter int DVS_W = 11
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   diff;

    // restoring division, one quotient bit per cycle
    always_comb begin
        rem_sh    = {rem_reg, quo_reg[DVD_W-1]};
        diff      = rem_sh - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[hw/rtl/wws_ctrl.sv]
`default_nettype none

module wws_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    input  wire wws_pkg::sts_t  sts,
    output wws_pkg::cmd_t       cmd
);

    import wws_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ACC: begin
                if (s_valid && sts.last) state_next = ST_GSTART;
            end
            ST_GSTART: state_next = ST_GRUN;
            ST_GRUN: begin
                if (sts.div_done) state_next = ST_RSTART;
            end
            ST_RSTART: state_next = ST_RRUN;
            ST_RRUN: begin
                if (sts.div_done) state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) state_next = ST_ACC;
            end
            default: state_next = ST_ACC;
        endcase
    end

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_ACC: begin
                s_ready    = 1'b1;
                cmd.acc_en = s_valid;
            end
            ST_GSTART: cmd.div_start = 1'b1;
            ST_GRUN:   cmd.save_gmean = sts.div_done;
            ST_RSTART: begin
                cmd.div_start  = 1'b1;
                cmd.div_region = 1'b1;
            end
            ST_RRUN:   cmd.div_region = 1'b1;
            ST_LOAD: begin
                cmd.div_region = 1'b1;
                cmd.load_out   = out_free;
            end
            default: cmd = '0;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) m_valid_next = 1'b0;
        if (cmd.load_out) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACC;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

[hw/rtl/wws_dp.sv]
`default_nettype none

module wws_dp #(
    parameter int MAX_SAMPLES = wws_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = wws_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    input  wire logic [wws_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [wws_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic signed [SAMPLE_BITS-1:0]        s_sample,
    input  wire wws_pkg::cmd_t                        cmd,
    output wws_pkg::sts_t                             sts,
    output logic signed [SAMPLE_BITS-1:0]             m_global_min,
    output logic signed [SAMPLE_BITS-1:0]             m_global_max,
    output logic signed [SAMPLE_BITS-1:0]             m_global_mean,
    output logic signed [SAMPLE_BITS-1:0]             m_region_min,
    output logic signed [SAMPLE_BITS-1:0]             m_region_max,
    output logic [SAMPLE_BITS-1:0]                    m_region_spread,
    output logic signed [SAMPLE_BITS-1:0]             m_region_abs_peak,
    output logic signed [SAMPLE_BITS-1:0]             m_region_mean,
    output logic                                      m_region_valid,
    output logic                                      m_mean_valid
);

    import wws_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = SAMPLE_BITS + IDX_W;
    localparam int CW    = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;

    // configuration
    logic [CFG_DATA_W-1:0] sample_count_reg;
    logic [WIN_W-1:0]      window_start_reg;
    logic [WIN_W-1:0]      window_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= RST_SAMPLE_COUNT;
            window_start_reg <= RST_WINDOW_START;
            window_end_reg   <= RST_WINDOW_END;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SAMPLE_COUNT: sample_count_reg <= cfg_data;
                CFG_WINDOW_START: window_start_reg <= cfg_data[WIN_W-1:0];
                CFG_WINDOW_END:   window_end_reg   <= cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // accumulators
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic signed [SB-1:0]    all_min_reg, all_min_next;
    logic signed [SB-1:0]    all_max_reg, all_max_next;
    logic signed [SUM_W-1:0] all_sum_reg, all_sum_next;
    logic signed [SB-1:0]    win_min_reg, win_min_next;
    logic signed [SB-1:0]    win_max_reg, win_max_next;
    logic signed [SB-1:0]    win_peak_reg, win_peak_next;
    logic [SB-1:0]           win_mag_reg, win_mag_next;
    logic signed [SUM_W-1:0] win_sum_reg, win_sum_next;
    logic [CNT_W-1:0]        win_cnt_reg, win_cnt_next;

    logic [CW-1:0]           eff_count;
    logic [CW-1:0]           idx_ext;
    logic [CW-1:0]           idx_inc;
    logic [CW-1:0]           ws_ext;
    logic [CW-1:0]           last_ext;
    logic                    at_start;
    logic                    in_win;
    logic                    rvalid;
    logic                    mvalid;
    logic                    wave_last;
    logic [SB-1:0]           mag;
    logic signed [SUM_W-1:0] s_ext;

    always_comb begin
        if (sample_count_reg == '0)
            eff_count = CW'(1);
        else if (CW'(sample_count_reg) > CW'(MAX_SAMPLES))
            eff_count = CW'(MAX_SAMPLES);
        else
            eff_count = CW'(sample_count_reg);
    end

    assign idx_ext   = CW'(idx_reg);
    assign idx_inc   = idx_ext + CW'(1);
    assign ws_ext    = CW'(window_start_reg);
    assign last_ext  = CW'(window_end_reg) + CW'(1);
    assign at_start  = (idx_ext == ws_ext);
    assign in_win    = (idx_ext > ws_ext) && (idx_ext <= last_ext);
    assign rvalid    = (ws_ext <= idx_ext);
    assign mvalid    = rvalid && (win_cnt_reg != '0);
    assign mag       = s_sample[SB-1] ? (~s_sample + 1'b1) : s_sample;
    assign s_ext     = {{(SUM_W-SB){s_sample[SB-1]}}, s_sample};

    assign wave_last = (idx_inc >= eff_count);

    always_comb begin
        idx_next      = idx_reg;
        all_min_next  = all_min_reg;
        all_max_next  = all_max_reg;
        all_sum_next  = all_sum_reg;
        win_min_next  = win_min_reg;
        win_max_next  = win_max_reg;
        win_peak_next = win_peak_reg;
        win_mag_next  = win_mag_reg;
        win_sum_next  = win_sum_reg;
        win_cnt_next  = win_cnt_reg;
        if (cmd.load_out) begin
            idx_next      = '0;
            all_min_next  = '0;
            all_max_next  = '0;
            all_sum_next  = '0;
            win_min_next  = '0;
            win_max_next  = '0;
            win_peak_next = '0;
            win_mag_next  = '0;
            win_sum_next  = '0;
            win_cnt_next  = '0;
        end else if (cmd.acc_en) begin
            if (idx_reg == '0) begin
                all_min_next = s_sample;
                all_max_next = s_sample;
                all_sum_next = s_ext;
            end else begin
                if (s_sample < all_min_reg) all_min_next = s_sample;
                if (s_sample > all_max_reg) all_max_next = s_sample;
                all_sum_next = all_sum_reg + s_ext;
            end
            if (at_start) begin
                win_min_next  = s_sample;
                win_max_next  = s_sample;
                win_peak_next = s_sample;
                win_mag_next  = mag;
                // start past the region end: extremes only, no mean
                if (idx_ext <= last_ext) begin
                    win_sum_next = s_ext;
                    win_cnt_next = CNT_W'(1);
                end else begin
                    win_sum_next = '0;
                    win_cnt_next = '0;
                end
            end else if (in_win) begin
                if (s_sample < win_min_reg) win_min_next = s_sample;
                if (s_sample > win_max_reg) win_max_next = s_sample;
                if (mag > win_mag_reg) begin
                    win_mag_next  = mag;
                    win_peak_next = s_sample;
                end
                win_sum_next = win_sum_reg + s_ext;
                win_cnt_next = win_cnt_reg + 1'b1;
            end
            if (!wave_last) idx_next = idx_inc[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            all_min_reg  <= '0;
            all_max_reg  <= '0;
            all_sum_reg  <= '0;
            win_min_reg  <= '0;
            win_max_reg  <= '0;
            win_peak_reg <= '0;
            win_mag_reg  <= '0;
            win_sum_reg  <= '0;
            win_cnt_reg  <= '0;
        end else begin
            idx_reg      <= idx_next;
            all_min_reg  <= all_min_next;
            all_max_reg  <= all_max_next;
            all_sum_reg  <= all_sum_next;
            win_min_reg  <= win_min_next;
            win_max_reg  <= win_max_next;
            win_peak_reg <= win_peak_next;
            win_mag_reg  <= win_mag_next;
            win_sum_reg  <= win_sum_next;
            win_cnt_reg  <= win_cnt_next;
        end
    end

    // shared divider on magnitudes, sign restored afterwards
    logic signed [SUM_W-1:0] dvd_signed;
    logic [SUM_W-1:0]        dvd_mag;
    logic [CNT_W-1:0]        dvs;
    logic [SUM_W-1:0]        quo;
    logic                    div_done;
    logic                    neg_reg, neg_next;
    logic [SUM_W-1:0]        quo_signed;
    logic signed [SB-1:0]    gmean_reg, gmean_next;

    assign dvd_signed = cmd.div_region ? win_sum_reg : all_sum_reg;
    assign dvd_mag    = dvd_signed[SUM_W-1] ? (~dvd_signed + 1'b1) : dvd_signed;
    assign dvs        = cmd.div_region ? win_cnt_reg : idx_inc[CNT_W-1:0];

    wws_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dvd_mag),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quo)
    );

    assign sts = '{last: wave_last, div_done: div_done};

    assign neg_next   = cmd.div_start ? dvd_signed[SUM_W-1] : neg_reg;
    assign quo_signed = neg_reg ? (~quo + 1'b1) : quo;
    assign gmean_next = cmd.save_gmean ? quo_signed[SB-1:0] : gmean_reg;

    always_ff @(posedge aclk) begin
        neg_reg   <= neg_next;
        gmean_reg <= gmean_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_global_min      <= all_min_reg;
            m_global_max      <= all_max_reg;
            m_global_mean     <= gmean_reg;
            m_region_min      <= rvalid ? win_min_reg : '0;
            m_region_max      <= rvalid ? win_max_reg : '0;
            m_region_spread   <= rvalid ? (win_max_reg - win_min_reg) : '0;
            m_region_abs_peak <= rvalid ? win_peak_reg : '0;
            m_region_mean     <= mvalid ? quo_signed[SB-1:0] : '0;
            m_region_valid    <= rvalid;
            m_mean_valid      <= mvalid;
        end
    end

endmodule

`default_nettype wire

[test/wws_stats_checker.sv]
// Watches the config, sample and result channels of the waveform statistics
// block, keeps a shadow copy of its registers and accumulators, and scores
// every result beat against the oldest predicted summary.
module wws_stats_checker #(
    parameter int SB   = wws_pkg::DEF_SAMPLE_BITS,
    parameter int NMAX = wws_pkg::DEF_MAX_SAMPLES
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [wws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wws_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           s_valid,
    input  wire logic                           s_ready,
    input  wire logic signed [SB-1:0]           s_sample,
    input  wire logic                           m_valid,
    input  wire logic                           m_ready,
    input  wire logic [SB-1:0]                  m_global_min,
    input  wire logic [SB-1:0]                  m_global_max,
    input  wire logic [SB-1:0]                  m_global_mean,
    input  wire logic [SB-1:0]                  m_region_min,
    input  wire logic [SB-1:0]                  m_region_max,
    input  wire logic [SB-1:0]                  m_region_spread,
    input  wire logic [SB-1:0]                  m_region_abs_peak,
    input  wire logic [SB-1:0]                  m_region_mean,
    input  wire logic                           m_region_valid,
    input  wire logic                           m_mean_valid,
    output int                                  mismatches,
    output int                                  waiting,
    output int                                  delivered
);
    import wws_pkg::*;

    typedef struct {
        logic [SB-1:0] gmin;
        logic [SB-1:0] gmax;
        logic [SB-1:0] gmean;
        logic [SB-1:0] rmin;
        logic [SB-1:0] rmax;
        logic [SB-1:0] rspread;
        logic [SB-1:0] rpeak;
        logic [SB-1:0] rmean;
        logic          rvalid;
        logic          mvalid;
    } wave_summary_t;

    wave_summary_t due_summaries[$];

    logic [CFG_DATA_W-1:0] count_reg = RST_SAMPLE_COUNT;
    logic [WIN_W-1:0]      start_reg = RST_WINDOW_START;
    logic [WIN_W-1:0]      end_reg   = RST_WINDOW_END;

    int sample_idx;
    int wave_min, wave_max, wave_sum;
    int reg_min, reg_max, reg_peak, reg_peak_mag, reg_sum, reg_count;
    int bad  = 0;
    int seen = 0;

    task automatic restart_waveform();
        sample_idx   = 0;
        wave_min     = 0;
        wave_max     = 0;
        wave_sum     = 0;
        reg_min      = 0;
        reg_max      = 0;
        reg_peak     = 0;
        reg_peak_mag = 0;
        reg_sum      = 0;
        reg_count    = 0;
    endtask

    // Fold one sample into the running statistics; on the last sample of a
    // waveform queue the summary the block must produce.
    task automatic absorb_sample(input int s);
        int mag, span, region_last, q;
        wave_summary_t r;
        mag = (s < 0) ? -s : s;
        span = int'(count_reg);
        if (span == 0) span = 1;
        if (span > NMAX) span = NMAX;
        region_last = int'(end_reg) + 1;

        if (sample_idx == 0) begin
            wave_min = s;
            wave_max = s;
            wave_sum = s;
        end else begin
            if (s < wave_min) wave_min = s;
            if (s > wave_max) wave_max = s;
            wave_sum += s;
        end

        if (sample_idx == int'(start_reg)) begin
            // region opens here; past its end it holds this sample but no count
            reg_min      = s;
            reg_max      = s;
            reg_peak     = s;
            reg_peak_mag = mag;
            reg_sum      = (sample_idx <= region_last) ? s : 0;
            reg_count    = (sample_idx <= region_last) ? 1 : 0;
        end else if (sample_idx > int'(start_reg) && sample_idx <= region_last) begin
            if (s < reg_min) reg_min = s;
            if (s > reg_max) reg_max = s;
            if (mag > reg_peak_mag) begin
                reg_peak_mag = mag;
                reg_peak     = s;
            end
            reg_sum += s;
            reg_count++;
        end

        if (sample_idx + 1 < span) begin
            sample_idx++;
        end else begin
            r = '{default: '0};
            q = wave_sum / (sample_idx + 1);
            r.gmin   = wave_min[SB-1:0];
            r.gmax   = wave_max[SB-1:0];
            r.gmean  = q[SB-1:0];
            r.rvalid = int'(start_reg) <= sample_idx;
            r.mvalid = r.rvalid && reg_count > 0;
            if (r.rvalid) begin
                q = reg_max - reg_min;
                r.rmin    = reg_min[SB-1:0];
                r.rmax    = reg_max[SB-1:0];
                r.rspread = q[SB-1:0];
                r.rpeak   = reg_peak[SB-1:0];
                q = r.mvalid ? reg_sum / reg_count : 0;
                r.rmean   = q[SB-1:0];
            end
            due_summaries.insert(due_summaries.size(), r);
            restart_waveform();
        end
    endtask

    task automatic check_field(input string name, input logic [SB-1:0] want,
                               input logic [SB-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%h, got 0x%h", name, want, got);
            bad++;
        end
    endtask

    always @(posedge aclk) begin
        wave_summary_t want;
        if (!aresetn) begin
            count_reg = RST_SAMPLE_COUNT;
            start_reg = RST_WINDOW_START;
            end_reg   = RST_WINDOW_END;
            restart_waveform();
            due_summaries.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SAMPLE_COUNT: count_reg = cfg_data;
                    CFG_WINDOW_START: start_reg = cfg_data[WIN_W-1:0];
                    CFG_WINDOW_END:   end_reg   = cfg_data[WIN_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                seen++;
                if (due_summaries.size() == 0) begin
                    $error("result beat with no waveform summary pending");
                    bad++;
                end else begin
                    want = due_summaries.pop_front();
                    check_field("global_min", want.gmin, m_global_min);
                    check_field("global_max", want.gmax, m_global_max);
                    check_field("global_mean", want.gmean, m_global_mean);
                    check_field("region_min", want.rmin, m_region_min);
                    check_field("region_max", want.rmax, m_region_max);
                    check_field("region_spread", want.rspread, m_region_spread);
                    check_field("region_abs_peak", want.rpeak, m_region_abs_peak);
                    check_field("region_mean", want.rmean, m_region_mean);
                    check_field("region_valid", SB'(want.rvalid), SB'(m_region_valid));
                    check_field("mean_valid", SB'(want.mvalid), SB'(m_mean_valid));
                end
            end
            if (s_valid && s_ready) absorb_sample(int'(s_sample));
        end
        mismatches <= bad;
        waiting    <= due_summaries.size();
        delivered  <= seen;
    end

endmodule

[test/waveform_window_statistics_tb.sv]
// Stimulus and verdict for the waveform statistics block. Scoring lives in
// wws_stats_checker; this module only drives the channels, programs the
// registers (at times in the middle of a waveform) and decides the outcome.
module waveform_window_statistics_tb;
    import wws_pkg::*;

    localparam int SB           = DEF_SAMPLE_BITS;
    localparam int QUIET        = 80;        // longer than the divide path at defaults
    localparam int STREAM_ITEMS = 740;       // random small-waveform samples
    localparam int LIMIT        = 1_000_000;

    // index with no register behind it; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

    localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_SAMPLE_COUNT;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic signed [SB-1:0]   s_sample  = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic signed [SB-1:0]   m_global_min, m_global_max, m_global_mean;
    logic signed [SB-1:0]   m_region_min, m_region_max;
    logic [SB-1:0]          m_region_spread;
    logic signed [SB-1:0]   m_region_abs_peak, m_region_mean;
    logic                   m_region_valid, m_mean_valid;

    int mismatches, waiting, delivered;

    bit idle_on    = 1'b1;   // random gaps/stalls allowed on both sides
    int items      = 0;      // accepted sample beats
    int settings   = 0;      // full register programs
    int cycles     = 0;
    int stall_left = 0;

    waveform_window_statistics dut (.*);

    wws_stats_checker u_checker (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: ready mostly high, dropped low in bursts of random length.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (aresetn && idle_on && $urandom_range(0, 7) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: sized for every sample producing a result and every result
    // waiting out a full stall, several times over.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $error("run stopped at the cycle limit");
            $display("FAIL");
            $finish;
        end
    end

    // Mix of extremes, sign boundary, small values and full-range noise.
    function automatic logic signed [SB-1:0] pick_sample();
        int v;
        case ($urandom_range(0, 7))
            0: return SMAX;
            1: return SMIN;
            2: return '0;
            3: return '1;
            4: begin
                v = int'($urandom_range(0, 200)) - 100;
                return v[SB-1:0];
            end
            default: begin
                v = $urandom;
                return v[SB-1:0];
            end
        endcase
    endfunction

    // One sample beat. Valid is only dropped ahead of an idle burst, so it
    // is never lowered and raised within the same step.
    task automatic send_sample(input logic signed [SB-1:0] value);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items++;
    endtask

    // Leaves cfg_valid high; the caller closes the burst of writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic program_window(input int count, input int first, input int stop);
        write_reg(CFG_SAMPLE_COUNT, count[CFG_DATA_W-1:0]);
        write_reg(CFG_WINDOW_START, first[CFG_DATA_W-1:0]);
        write_reg(CFG_WINDOW_END, stop[CFG_DATA_W-1:0]);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // Stop sending, let every predicted result come back, then give the
    // divider time to finish before anything touches the registers. The
    // first edge lets the checker's pending count catch up.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (waiting != 0) @(posedge aclk);
        repeat (QUIET) @(posedge aclk);
    endtask

    // One random register setting followed by a stream of samples. Most
    // counts are small so results come often; windows are drawn inside,
    // past the end, inverted, or at the register extremes. The stream may
    // stop mid-waveform, so the next program lands in the middle of one.
    task automatic run_setting();
        int count, span, first, stop, n;
        case ($urandom_range(0, 9))
            0:       count = 0;
            1:       count = $urandom_range(41, 200);
            default: count = $urandom_range(1, 40);
        endcase
        span = (count == 0) ? 1 : count;
        case ($urandom_range(0, 9))
            0:       first = 1023;
            1:       first = span + $urandom_range(0, 3);     // region invalid
            default: first = $urandom_range(0, span - 1);
        endcase
        case ($urandom_range(0, 9))
            0:       stop = 1023;
            1:       stop = 0;
            2:       stop = (first >= 2) ? $urandom_range(0, first - 2) : 0;  // inverted
            default: stop = $urandom_range(first, span + 1);
        endcase
        // top data bit lies outside the 10-bit window registers
        first[WIN_W] = $urandom_range(0, 1);
        stop[WIN_W]  = $urandom_range(0, 1);

        drain();
        program_window(count, first, stop);
        idle_on = ($urandom_range(0, 3) != 0);
        n = (span > 40) ? span : $urandom_range(1, 4) * span;
        if ($urandom_range(0, 2) == 0) n += $urandom_range(1, span);
        repeat (n) send_sample(pick_sample());
    endtask

    initial begin
        int base;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Count 0 behaves as 1: each extreme sample is its own waveform.
        program_window(0, 0, 0);
        send_sample(SMAX);
        send_sample(SMIN);

        // Region 1..2 spans the full range: spread 65535, peak is the most
        // negative value, mean truncates toward zero.
        drain();
        program_window(4, 1, 1);
        send_sample(SMAX);
        send_sample(SMIN);
        send_sample(SMAX);
        send_sample(SMIN);

        // Equal magnitudes: the first one keeps the peak.
        drain();
        program_window(5, 0, 3);
        send_sample(16'sd9);
        send_sample(-16'sd9);
        send_sample(16'sd3);
        send_sample(16'sd9);
        send_sample(-16'sd2);

        // Start beyond the waveform: region flagged invalid; negative mean.
        drain();
        program_window(3, 1023, 1023);
        send_sample(-16'sd3);
        send_sample(-16'sd4);
        send_sample(-16'sd4);

        // Inverted window: region holds only the start sample, no mean.
        drain();
        program_window(4, 3, 0);
        send_sample(16'sd1);
        send_sample(16'sd2);
        send_sample(16'sd3);
        send_sample(-16'sd100);

        // Count lowered mid-waveform below the index already reached: the
        // next sample ends it, mean over four samples, start never reached.
        drain();
        program_window(8, 5, 6);
        repeat (3) send_sample(pick_sample());
        drain();
        write_reg(CFG_SAMPLE_COUNT, 11'd2);
        cfg_valid <= 1'b0;
        send_sample(pick_sample());

        // Write to an unused index, then a region clipped at index 1024.
        drain();
        write_reg(CFG_NO_REG, '1);
        program_window(2, 1, 1023);
        send_sample(SMIN);
        send_sample(SMIN);

        // Random settings, mostly short waveforms.
        base = items;
        while (items - base < STREAM_ITEMS) run_setting();

        // Closing stretch at full rate on both sides.
        drain();
        idle_on = 1'b0;
        program_window(6, 1, 3);
        repeat (36) send_sample(pick_sample());

        drain();
        $display("Streamed %0d samples over %0d register programs, with %0d results checked;",
                 items, settings, delivered);
        $display("covered clamped counts, inverted and out-of-range windows, mid-waveform writes.");
        if (mismatches == 0 && waiting == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
